>>> rtl/dtfp_pkg.sv
// Shared constants, types and helper functions for the decimal text parser.
// No dependencies; every other file of the block refers to this package.
`timescale 1ns / 1ps
`default_nettype none

package dtfp_pkg;

  localparam int INT_DIGITS  = 18;
  localparam int FRAC_DIGITS = 9;

  localparam int CHAR_W = 8;
  localparam int INT_W  = 61;   // integer_part width, signed
  localparam int FRAC_W = 31;   // fraction_part width, signed
  localparam int IACC_W = 60;
  localparam int FACC_W = 30;
  localparam int ICNT_W = 5;    // saturates at INT_DIGITS + 1
  localparam int ACNT_W = 4;    // saturates at ACNT_MAX
  localparam int FCNT_W = 4;
  localparam int EXP_W  = 4;

  localparam int ACNT_MAX = 15;
  localparam int QDEPTH   = 2;

  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  localparam logic [IACC_W-1:0] INT_NINES  = 60'd999999999999999999;
  localparam logic [FACC_W-1:0] FRAC_NINES = 30'd999999999;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_BAD_MINUS = 1'b1;

  // One finished string, handed from the scanner to the scaling stage.
  typedef struct packed {
    logic              bad_sign;
    logic              saturate;
    logic              negative;
    logic [IACC_W-1:0] int_acc;
    logic [FACC_W-1:0] frac_acc;
    logic [EXP_W-1:0]  scale_exp;
  } dtfp_rec_t;

  function automatic logic [FACC_W-1:0] pow10_frac(input logic [EXP_W-1:0] e);
    logic [FACC_W-1:0] r;
    case (e)
      4'd0:    r = 30'd1;
      4'd1:    r = 30'd10;
      4'd2:    r = 30'd100;
      4'd3:    r = 30'd1000;
      4'd4:    r = 30'd10000;
      4'd5:    r = 30'd100000;
      4'd6:    r = 30'd1000000;
      4'd7:    r = 30'd10000000;
      4'd8:    r = 30'd100000000;
      4'd9:    r = 30'd1000000000;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/dtfp_in_if.sv
// Character channel of the decimal text parser: valid/ready plus payload.
// Depends on dtfp_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface dtfp_in_if;
  logic                        valid;
  logic                        ready;
  logic [dtfp_pkg::CHAR_W-1:0] character;
  logic                        last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

`default_nettype wire

>>> rtl/dtfp_out_if.sv
// Result channel of the decimal text parser: valid/ready plus payload.
// Depends on dtfp_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface dtfp_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [dtfp_pkg::INT_W-1:0]  integer_part;
  logic signed [dtfp_pkg::FRAC_W-1:0] fraction_part;
  logic                              status;

  modport source (output valid, output integer_part, output fraction_part,
                  output status, input ready);
  modport sink   (input valid, input integer_part, input fraction_part,
                  input status, output ready);
endinterface

`default_nettype wire

>>> rtl/decimal_text_to_fixed_parser.sv
// Decimal text to fixed-point parser, top level.
// Built from dtfp_front, dtfp_queue and dtfp_back; uses dtfp_pkg and the
// dtfp_in_if / dtfp_out_if channel interfaces.
//
// in_i carries one ASCII character per transaction, with last set on the
// final character of a string. out_o carries one transaction per string:
// a signed integer part, a signed fraction in units of 1e-9, and a status
// (0 ok, 1 misplaced minus, parts then zero).
// Throughput: one character per cycle while the queue has room, strings back
// to back with no gap; the scanner updates all counters and accumulators on
// each accepted character. out_o.valid rises once the record has passed the
// queue write, the scale multiply stage and the output register.
// A two-entry queue sits between scanner and scaling stage; when out_o
// stalls, the output and scale stages hold and the queue fills. in_i.ready
// follows the queue: it is low for every character while the queue is full
// and rises once the scaling stage takes a record.
// Reset clears the scanner to the start-of-string state and empties the
// queue and the pipeline; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module decimal_text_to_fixed_parser (
  input  wire         clk_i,
  input  wire         rst_ni,
  dtfp_in_if.sink     in_i,
  dtfp_out_if.source  out_o
);

  logic                q_push_valid, q_push_ready;
  logic                q_pop_valid, q_pop_ready;
  dtfp_pkg::dtfp_rec_t q_push_rec, q_pop_rec;

  dtfp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (q_push_valid),
    .push_rec_o   (q_push_rec),
    .push_ready_i (q_push_ready)
  );

  dtfp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (q_push_valid),
    .push_rec_i   (q_push_rec),
    .push_ready_o (q_push_ready),
    .pop_valid_o  (q_pop_valid),
    .pop_rec_o    (q_pop_rec),
    .pop_ready_i  (q_pop_ready)
  );

  dtfp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (q_pop_valid),
    .pop_rec_i   (q_pop_rec),
    .pop_ready_o (q_pop_ready),
    .out_o       (out_o)
  );

  // an error result carries zero parts
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status == dtfp_pkg::STATUS_BAD_MINUS) |->
      (out_o.integer_part == '0 && out_o.fraction_part == '0))
    else $error("error result with nonzero parts");

  // fraction never exceeds nine nines in magnitude
  a_frac_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |->
      ($signed(out_o.fraction_part) <= $signed(32'sd999999999) &&
       $signed(out_o.fraction_part) >= $signed(-32'sd999999999)))
    else $error("fraction out of range");

  // a plain record taken from the queue holds at most eighteen digits
  a_pop_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop_valid && q_pop_ready && !q_pop_rec.saturate && !q_pop_rec.bad_sign) |->
      (q_pop_rec.int_acc <= dtfp_pkg::INT_NINES))
    else $error("integer accumulator beyond eighteen digits");

endmodule

`default_nettype wire

>>> rtl/dtfp_front.sv
// Character scanner: one character per cycle while the queue has room; tracks
// runs and counts, queues one record per string. Uses dtfp_pkg, dtfp_in_if.
`timescale 1ns / 1ps
`default_nettype none

module dtfp_front (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  dtfp_in_if.sink              in_i,
  output logic                 push_valid_o,
  output dtfp_pkg::dtfp_rec_t  push_rec_o,
  input  wire                  push_ready_i
);

  logic is_first_q, is_first_d;
  logic negative_q, negative_d;
  logic bad_sign_q, bad_sign_d;
  logic seen_point_q, seen_point_d;
  logic in_int_run_q, in_int_run_d;
  logic frac_active_q, frac_active_d;
  logic [dtfp_pkg::ICNT_W-1:0] int_cnt_q, int_cnt_d;
  logic [dtfp_pkg::ACNT_W-1:0] apt_cnt_q, apt_cnt_d;
  logic [dtfp_pkg::FCNT_W-1:0] frac_cnt_q, frac_cnt_d;
  logic [dtfp_pkg::IACC_W-1:0] int_acc_q, int_acc_d;
  logic [dtfp_pkg::FACC_W-1:0] frac_acc_q, frac_acc_d;

  // state after this character, before the end-of-string clear
  logic upd_negative, upd_bad_sign, upd_seen_point, upd_in_int_run, upd_frac_active;
  logic [dtfp_pkg::ICNT_W-1:0] upd_int_cnt;
  logic [dtfp_pkg::ACNT_W-1:0] upd_apt_cnt;
  logic [dtfp_pkg::FCNT_W-1:0] upd_frac_cnt;
  logic [dtfp_pkg::IACC_W-1:0] upd_int_acc;
  logic [dtfp_pkg::FACC_W-1:0] upd_frac_acc;

  logic accept;
  logic is_minus;
  logic is_digit;
  logic [3:0] digit;

  assign in_i.ready   = push_ready_i;
  assign accept       = in_i.valid && in_i.ready;
  assign push_valid_o = in_i.valid && in_i.last;

  assign is_minus = (in_i.character == dtfp_pkg::CH_MINUS);
  assign is_digit = (in_i.character >= dtfp_pkg::CH_ZERO) &&
                    (in_i.character <= dtfp_pkg::CH_NINE);
  assign digit    = in_i.character[3:0];

  always_comb begin
    upd_negative    = negative_q;
    upd_bad_sign    = bad_sign_q;
    upd_seen_point  = seen_point_q;
    upd_in_int_run  = in_int_run_q;
    upd_frac_active = frac_active_q;
    upd_int_cnt     = int_cnt_q;
    upd_apt_cnt     = apt_cnt_q;
    upd_frac_cnt    = frac_cnt_q;
    upd_int_acc     = int_acc_q;
    upd_frac_acc    = frac_acc_q;

    if (is_first_q && is_minus) begin
      upd_negative = 1'b1;
    end else begin
      if (is_minus) upd_bad_sign = 1'b1;
      if (!seen_point_q) begin
        if (in_i.character == dtfp_pkg::CH_POINT) begin
          upd_seen_point  = 1'b1;
          upd_frac_active = in_int_run_q;
          upd_in_int_run  = 1'b0;
        end else begin
          if (in_int_run_q && is_digit &&
              int_cnt_q < dtfp_pkg::ICNT_W'(dtfp_pkg::INT_DIGITS)) begin
            // x*10 as x*8 + x*2
            upd_int_acc = (int_acc_q << 3) + (int_acc_q << 1) +
                          dtfp_pkg::IACC_W'(digit);
          end else begin
            upd_in_int_run = 1'b0;
          end
          if (int_cnt_q <= dtfp_pkg::ICNT_W'(dtfp_pkg::INT_DIGITS))
            upd_int_cnt = int_cnt_q + 1'b1;
        end
      end else begin
        if (apt_cnt_q < dtfp_pkg::ACNT_W'(dtfp_pkg::ACNT_MAX))
          upd_apt_cnt = apt_cnt_q + 1'b1;
        if (frac_active_q) begin
          if (is_digit && frac_cnt_q < dtfp_pkg::FCNT_W'(dtfp_pkg::FRAC_DIGITS)) begin
            upd_frac_acc = (frac_acc_q << 3) + (frac_acc_q << 1) +
                           dtfp_pkg::FACC_W'(digit);
            upd_frac_cnt = frac_cnt_q + 1'b1;
          end else begin
            upd_frac_active = 1'b0;
          end
        end
      end
    end
  end

  always_comb begin
    push_rec_o.bad_sign = upd_bad_sign;
    push_rec_o.saturate = (upd_int_cnt > dtfp_pkg::ICNT_W'(dtfp_pkg::INT_DIGITS));
    push_rec_o.negative = upd_negative;
    push_rec_o.int_acc  = upd_int_acc;
    push_rec_o.frac_acc = upd_frac_acc;
    if (upd_apt_cnt < dtfp_pkg::ACNT_W'(dtfp_pkg::FRAC_DIGITS))
      push_rec_o.scale_exp = dtfp_pkg::EXP_W'(dtfp_pkg::FRAC_DIGITS) -
                             dtfp_pkg::EXP_W'(upd_apt_cnt);
    else
      push_rec_o.scale_exp = '0;
  end

  always_comb begin
    is_first_d    = is_first_q;
    negative_d    = negative_q;
    bad_sign_d    = bad_sign_q;
    seen_point_d  = seen_point_q;
    in_int_run_d  = in_int_run_q;
    frac_active_d = frac_active_q;
    int_cnt_d     = int_cnt_q;
    apt_cnt_d     = apt_cnt_q;
    frac_cnt_d    = frac_cnt_q;
    int_acc_d     = int_acc_q;
    frac_acc_d    = frac_acc_q;
    if (accept) begin
      if (in_i.last) begin
        // string done: back to the start-of-string state
        is_first_d    = 1'b1;
        negative_d    = 1'b0;
        bad_sign_d    = 1'b0;
        seen_point_d  = 1'b0;
        in_int_run_d  = 1'b1;
        frac_active_d = 1'b0;
        int_cnt_d     = '0;
        apt_cnt_d     = '0;
        frac_cnt_d    = '0;
        int_acc_d     = '0;
        frac_acc_d    = '0;
      end else begin
        is_first_d    = 1'b0;
        negative_d    = upd_negative;
        bad_sign_d    = upd_bad_sign;
        seen_point_d  = upd_seen_point;
        in_int_run_d  = upd_in_int_run;
        frac_active_d = upd_frac_active;
        int_cnt_d     = upd_int_cnt;
        apt_cnt_d     = upd_apt_cnt;
        frac_cnt_d    = upd_frac_cnt;
        int_acc_d     = upd_int_acc;
        frac_acc_d    = upd_frac_acc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      is_first_q    <= 1'b1;
      negative_q    <= 1'b0;
      bad_sign_q    <= 1'b0;
      seen_point_q  <= 1'b0;
      in_int_run_q  <= 1'b1;
      frac_active_q <= 1'b0;
      int_cnt_q     <= '0;
      apt_cnt_q     <= '0;
      frac_cnt_q    <= '0;
      int_acc_q     <= '0;
      frac_acc_q    <= '0;
    end else begin
      is_first_q    <= is_first_d;
      negative_q    <= negative_d;
      bad_sign_q    <= bad_sign_d;
      seen_point_q  <= seen_point_d;
      in_int_run_q  <= in_int_run_d;
      frac_active_q <= frac_active_d;
      int_cnt_q     <= int_cnt_d;
      apt_cnt_q     <= apt_cnt_d;
      frac_cnt_q    <= frac_cnt_d;
      int_acc_q     <= int_acc_d;
      frac_acc_q    <= frac_acc_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/dtfp_queue.sv
// Short record queue between the scanner and the scaling stage.
// Depends on dtfp_pkg for the record type and depth.
`timescale 1ns / 1ps
`default_nettype none

module dtfp_queue (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_valid_i,
  input  dtfp_pkg::dtfp_rec_t  push_rec_i,
  output logic                 push_ready_o,
  output logic                 pop_valid_o,
  output dtfp_pkg::dtfp_rec_t  pop_rec_o,
  input  wire                  pop_ready_i
);

  localparam int PTR_W = (dtfp_pkg::QDEPTH > 1) ? $clog2(dtfp_pkg::QDEPTH) : 1;
  localparam int CNT_W = $clog2(dtfp_pkg::QDEPTH + 1);

  dtfp_pkg::dtfp_rec_t entry_q [dtfp_pkg::QDEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic push, pop;

  assign push_ready_o = (count_q != CNT_W'(dtfp_pkg::QDEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_rec_o    = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push)
      wr_ptr_d = (wr_ptr_q == PTR_W'(dtfp_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    if (pop)
      rd_ptr_d = (rd_ptr_q == PTR_W'(dtfp_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    if (push && !pop)
      count_d = count_q + 1'b1;
    else if (pop && !push)
      count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) entry_q[wr_ptr_q] <= push_rec_i;
  end

endmodule

`default_nettype wire

>>> rtl/dtfp_back.sv
// Scaling and sign stage: scales the fraction, applies saturation, error and
// sign, and holds the result register. Uses dtfp_pkg and dtfp_out_if.
`timescale 1ns / 1ps
`default_nettype none

module dtfp_back (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  pop_valid_i,
  input  dtfp_pkg::dtfp_rec_t  pop_rec_i,
  output logic                 pop_ready_o,
  dtfp_out_if.source           out_o
);

  localparam int PROD_W = 2 * dtfp_pkg::FACC_W;

  // stage A: scaled magnitudes
  logic                        a_valid_q;
  logic                        a_neg_q, a_bad_q;
  logic [dtfp_pkg::IACC_W-1:0] a_ip_q, a_ip_d;
  logic [dtfp_pkg::FACC_W-1:0] a_fp_q, a_fp_d;
  logic [PROD_W-1:0]           product;

  // stage B: output register
  logic                                out_valid_q;
  logic signed [dtfp_pkg::INT_W-1:0]   out_ip_q;
  logic signed [dtfp_pkg::FRAC_W-1:0]  out_fp_q;
  logic                                out_status_q;

  logic b_ready, a_ready;
  logic [dtfp_pkg::INT_W-1:0]  ip_ext;
  logic [dtfp_pkg::FRAC_W-1:0] fp_ext;

  assign b_ready     = !out_valid_q || out_o.ready;
  assign a_ready     = !a_valid_q || b_ready;
  assign pop_ready_o = a_ready;

  assign product = PROD_W'(pop_rec_i.frac_acc) *
                   PROD_W'(dtfp_pkg::pow10_frac(pop_rec_i.scale_exp));

  always_comb begin
    if (pop_rec_i.bad_sign) begin
      a_ip_d = '0;
      a_fp_d = '0;
    end else if (pop_rec_i.saturate) begin
      a_ip_d = dtfp_pkg::INT_NINES;
      a_fp_d = dtfp_pkg::FRAC_NINES;
    end else begin
      a_ip_d = pop_rec_i.int_acc;
      a_fp_d = product[dtfp_pkg::FACC_W-1:0];
    end
  end

  assign ip_ext = {1'b0, a_ip_q};
  assign fp_ext = {1'b0, a_fp_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (a_ready) a_valid_q <= pop_valid_i;
      if (b_ready) out_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && pop_valid_i) begin
      a_neg_q <= pop_rec_i.negative;
      a_bad_q <= pop_rec_i.bad_sign;
      a_ip_q  <= a_ip_d;
      a_fp_q  <= a_fp_d;
    end
    if (b_ready && a_valid_q) begin
      out_ip_q     <= a_neg_q ? $signed('0 - ip_ext) : $signed(ip_ext);
      out_fp_q     <= a_neg_q ? $signed('0 - fp_ext) : $signed(fp_ext);
      out_status_q <= a_bad_q ? dtfp_pkg::STATUS_BAD_MINUS : dtfp_pkg::STATUS_OK;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.integer_part  = out_ip_q;
  assign out_o.fraction_part = out_fp_q;
  assign out_o.status        = out_status_q;

endmodule

`default_nettype wire
